// ===== design/indexed_deque_with_sort_unit_assert.svh =====
// Assertion macros for the indexed deque with sort unit.
`ifndef INDEXED_DEQUE_WITH_SORT_UNIT_ASSERT_SVH
`define INDEXED_DEQUE_WITH_SORT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IDWSU_ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
    else $error("indexed deque: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IDWSU_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
    else $error("indexed deque: next-cycle check failed");

`endif

// ===== design/idwsu_pkg.sv =====
// Types, constants and helper functions of the indexed deque with sort unit.
package idwsu_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDXW       = $clog2(DEPTH);
  localparam int CNTW       = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int POS_W      = 6;
  localparam int VALUE_W    = 32;
  localparam int STAT_W     = 2;
  localparam int COUNT_W    = 7;
  localparam int CMPW       = (CNTW > POS_W) ? CNTW : POS_W;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_READ       = 3'd1,
    OP_WRITE      = 3'd2,
    OP_TAKE_FIRST = 3'd3,
    OP_TAKE_LAST  = 3'd4,
    OP_TAKE_AT    = 3'd5,
    OP_SORT       = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_RIGHT,
    SEL_LEFT
  } cell_sel_e;

  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_t;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
    logic                      ascending;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        entry_count;
  } out_t;

  function automatic word_t to_word(logic signed [VALUE_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

  function automatic logic signed [VALUE_W-1:0] to_result(word_t w);
    return VALUE_W'(w);
  endfunction

endpackage

// ===== design/idwsu_cell.sv =====
// One storage cell of the deque row: holds a word, loads, shifts and compares.
module idwsu_cell (
  input  logic                  clk_i,
  input  idwsu_pkg::cell_sel_e  sel_i,
  input  idwsu_pkg::word_t      load_i,
  input  idwsu_pkg::word_t      left_i,
  input  idwsu_pkg::word_t      right_i,
  output idwsu_pkg::word_t      word_o,
  output idwsu_pkg::cmp_t       cmp_o
);
  import idwsu_pkg::*;

  word_t word_q, word_d;

  always_comb begin
    case (sel_i)
      SEL_LOAD:  word_d = load_i;
      SEL_RIGHT: word_d = right_i;
      SEL_LEFT:  word_d = left_i;
      default:   word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o   = word_q;
  assign cmp_o.gt = word_q > right_i;
  assign cmp_o.lt = word_q < right_i;

endmodule

// ===== design/indexed_deque_with_sort_unit.sv =====
// Top level of the indexed deque with sort: cell row, control and result register.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one item per
// operation; output channel out_valid_o / out_stall_i / out_data_o returns one
// result item per input item, in order.
// An item is taken at a rising edge with valid high and stall low.
// Append, read, write and the three take operations finish at the accepting
// edge: the result is registered there and shown on the next cycle, and
// the row of cells loads or shifts by one place in that same edge.
// Back-to-back items run at one per cycle while the receiver takes results and no sort is running.
// Sort runs DEPTH odd-even transposition phases over the cell row, one phase
// a cycle, and then presents its result, with no item accepted meanwhile.
// When the receiver stalls, the result register holds its item and the input
// channel stalls until that item leaves; an item can be taken in the cycle
// the held result drains.
// Reset empties the list (count zero) and clears the output valid; cell
// contents are not cleared, entries at or past the count are never read.
`include "indexed_deque_with_sort_unit_assert.svh"

module indexed_deque_with_sort_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  idwsu_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output idwsu_pkg::out_t  out_data_o
);
  import idwsu_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SORT
  } state_e;

  state_e           state_q, state_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic [IDXW-1:0]  sort_ctr_q, sort_ctr_d;
  logic             asc_q, asc_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_data_q, out_data_d;

  word_t            words [DEPTH];
  cmp_t             cmps  [DEPTH];
  cell_sel_e        sels  [DEPTH];
  logic [DEPTH-1:0] swap;

  logic             in_acc;
  logic [CMPW-1:0]  pos_c, cnt_c;
  logic             pos_ok, empty, full;
  logic [IDXW-1:0]  pos_idx, last_idx;
  logic [CNTW-1:0]  cnt_m1;
  word_t            val_w;
  logic             load_en, shift_en;
  logic [IDXW-1:0]  load_idx, shift_from;
  logic             sorting, sort_last;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pos_c    = CMPW'(in_data_i.position);
  assign cnt_c    = CMPW'(count_q);
  assign pos_ok   = pos_c < cnt_c;
  assign pos_idx  = pos_c[IDXW-1:0];
  assign cnt_m1   = count_q - 1'b1;
  assign last_idx = cnt_m1[IDXW-1:0];
  assign empty    = count_q == '0;
  assign full     = count_q == CNTW'(DEPTH);
  assign val_w    = to_word(in_data_i.value);

  assign sorting   = state_q == ST_SORT;
  assign sort_last = sort_ctr_q == IDXW'(DEPTH - 1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sort_ctr_d  = sort_ctr_q;
    asc_d       = asc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    load_en     = 1'b0;
    load_idx    = '0;
    shift_en    = 1'b0;
    shift_from  = '0;

    if (sorting) begin
      sort_ctr_d = sort_ctr_q + 1'b1;
      if (sort_last) begin
        state_d                 = ST_IDLE;
        out_valid_d             = 1'b1;
        out_data_d.result_value = '0;
        out_data_d.status       = STAT_OK;
        out_data_d.entry_count  = COUNT_W'(count_q);
      end
    end else if (in_acc) begin
      out_data_d.result_value = '0;
      out_data_d.status       = STAT_OK;
      case (op_e'(in_data_i.operation))
        OP_APPEND: begin
          if (full) begin
            out_data_d.status = STAT_FULL;
          end else begin
            load_en  = 1'b1;
            load_idx = count_q[IDXW-1:0];
            count_d  = count_q + 1'b1;
          end
        end
        OP_READ: begin
          if (pos_ok) begin
            out_data_d.result_value = to_result(words[pos_idx]);
          end else begin
            out_data_d.status = STAT_RANGE;
          end
        end
        OP_WRITE: begin
          if (pos_ok) begin
            load_en  = 1'b1;
            load_idx = pos_idx;
          end else begin
            out_data_d.status = STAT_RANGE;
          end
        end
        OP_TAKE_FIRST: begin
          if (empty) begin
            out_data_d.status = STAT_RANGE;
          end else begin
            out_data_d.result_value = to_result(words[0]);
            shift_en = 1'b1;
            count_d  = cnt_m1;
          end
        end
        OP_TAKE_LAST: begin
          if (empty) begin
            out_data_d.status = STAT_RANGE;
          end else begin
            out_data_d.result_value = to_result(words[last_idx]);
            count_d = cnt_m1;
          end
        end
        OP_TAKE_AT: begin
          if (pos_ok) begin
            out_data_d.result_value = to_result(words[pos_idx]);
            shift_en   = 1'b1;
            shift_from = pos_idx;
            count_d    = cnt_m1;
          end else begin
            out_data_d.status = STAT_RANGE;
          end
        end
        OP_SORT: begin
          state_d    = ST_SORT;
          sort_ctr_d = '0;
          asc_d      = in_data_i.ascending;
        end
        default: begin
        end
      endcase
      out_data_d.entry_count = COUNT_W'(count_d);
      if (op_e'(in_data_i.operation) != OP_SORT) begin
        out_valid_d = 1'b1;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [IDXW-1:0] IDX = IDXW'(i);
    localparam logic [CNTW-1:0] NXT = CNTW'(i + 1);
    localparam logic            PAR = (i % 2) == 1;

    word_t left_w, right_w;

    if (i == DEPTH - 1) begin : g_last
      assign swap[i]  = 1'b0;
      assign right_w  = '0;
    end else begin : g_pair
      assign swap[i]  = sorting && (sort_ctr_q[0] == PAR) && (NXT < count_q) &&
                        (asc_q ? cmps[i].gt : cmps[i].lt);
      assign right_w  = words[i+1];
    end

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = words[i-1];
    end

    always_comb begin
      sels[i] = SEL_HOLD;
      if (load_en && (load_idx == IDX)) begin
        sels[i] = SEL_LOAD;
      end
      if (shift_en && (IDX >= shift_from) && (i != DEPTH - 1)) begin
        sels[i] = SEL_RIGHT;
      end
      if (swap[i]) begin
        sels[i] = SEL_RIGHT;
      end
      if ((i != 0) && swap[(i == 0) ? 0 : i-1]) begin
        sels[i] = SEL_LEFT;
      end
    end

    idwsu_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (sels[i]),
      .load_i  (val_w),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[i]),
      .cmp_o   (cmps[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sort_ctr_q  <= '0;
      asc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sort_ctr_q  <= sort_ctr_d;
      asc_q       <= asc_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `IDWSU_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNTW'(DEPTH))
  `IDWSU_ASSERT_IMPLY(a_sort_no_out, clk_i, rst_ni, sorting, !out_valid_q)
  `IDWSU_ASSERT_NEXT(a_result_follows, clk_i, rst_ni,
                     in_acc && (in_data_i.operation != OP_SORT), out_valid_q)
  `IDWSU_ASSERT_IMPLY(a_full_count, clk_i, rst_ni,
                      out_valid_q && (out_data_q.status == STAT_FULL),
                      out_data_q.entry_count == COUNT_W'(DEPTH))

endmodule
